>>> rtl/csl_pkg.sv
// Package for the clustered sine length generator.
// Holds counts, register and action codes, sequencer constants and the sine table.
// No dependencies.
package csl_pkg;

	localparam int MUSCLE_COUNT = 24;
	localparam int CLUSTER_COUNT = 8;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_REST_LENGTH = 2'd0;
	localparam logic [1:0] REG_STRETCH_FACTOR = 2'd1;
	localparam logic [1:0] REG_DC_OFFSET = 2'd2;

	// Item kinds.
	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_TICK = 1'b1;

	// round(2^32 / (2*pi)): radians in Q24.24 times this gives a binary angle at bit 40.
	localparam logic [29:0] TURN_SCALE = 30'd683565276;

	localparam logic [4:0] LAST_MUSCLE = 5'd23;
	localparam logic [2:0] LAST_CLUSTER = 3'd7;
	// Clusters below this one drive four muscles, the others two.
	localparam logic [2:0] FIRST_PAIR_CLUSTER = 3'd4;

	// Quarter-wave sine, sin(k*pi/32)*32767; entry 17 repeats the peak so the step is zero.
	function automatic logic [14:0] quarter_sine(input logic [4:0] k);
		logic [14:0] v;
		case (k)
			5'd0: v = 15'd0;
			5'd1: v = 15'd3212;
			5'd2: v = 15'd6393;
			5'd3: v = 15'd9512;
			5'd4: v = 15'd12539;
			5'd5: v = 15'd15447;
			5'd6: v = 15'd18204;
			5'd7: v = 15'd20787;
			5'd8: v = 15'd23170;
			5'd9: v = 15'd25329;
			5'd10: v = 15'd27245;
			5'd11: v = 15'd28898;
			5'd12: v = 15'd30273;
			5'd13: v = 15'd31356;
			5'd14: v = 15'd32137;
			5'd15: v = 15'd32609;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/csl_in_if.sv
// Input channel of the clustered sine length generator: valid, ready and one input item.
// Depends on nothing but the field widths it declares.
interface csl_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [2:0] cluster_index;
	logic [15:0] amplitude;
	logic [15:0] angular_rate;
	logic signed [15:0] phase_step;
	logic [15:0] time_step;

	modport source(output valid, action, cluster_index, amplitude, angular_rate,
		phase_step, time_step, input ready);
	modport sink(input valid, action, cluster_index, amplitude, angular_rate,
		phase_step, time_step, output ready);
endinterface

>>> rtl/csl_out_if.sv
// Output channel of the clustered sine length generator: valid, ready and one result item.
// Depends on nothing but the field widths it declares.
interface csl_out_if;
	logic valid;
	logic ready;
	logic [4:0] muscle_index;
	logic [15:0] target_length;
	logic last;

	modport source(output valid, muscle_index, target_length, last, input ready);
	modport sink(input valid, muscle_index, target_length, last, output ready);
endinterface

>>> rtl/clustered_sine_length_generator.sv
// Top level of the clustered sine length generator.
// Uses csl_pkg and the csl_in_if / csl_out_if channel interfaces.
//
// Usage:
// in_ch takes two kinds of item. A write item (action 0) stores amplitude, angular rate
// and phase step for one of eight clusters. A tick item (action 1) adds time_step to
// the elapsed time and produces 24 items on out_ch, muscles 0 to 23, the last one
// flagged with last.
// All products run through one shift-add multiplier that handles one multiplier bit
// per cycle. After the tick is taken, it first computes the two clamp limits, then
// for each cluster the products rate times time, turn scale, interpolation and
// amplitude, and then emits the lengths of that cluster.
// Lengths of one cluster are equal and go out back to back, one per cycle while out_ch is ready.
// in_ch is ready only while no tick is in progress; the final item of a tick may
// still wait in the output register while the next item is taken.
// When out_ch stalls, the sequencer holds at the next length until the output
// register frees up.
// Reset clears the tables, elapsed time and the output valid, and loads the
// registers with rest length 1.0, stretch factor 0.5 and offset 1.0.
// The configuration port writes one register per cycle with cfg_we; the user must write
// it only while the block is idle, which the block itself does not enforce.
module clustered_sine_length_generator (
	input  logic clk,
	input  logic arst_n,
	csl_in_if.sink in_ch,
	csl_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import csl_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LIM_LO = 3'd1;
	localparam logic [2:0] ST_LIM_HI = 3'd2;
	localparam logic [2:0] ST_RATE = 3'd3;
	localparam logic [2:0] ST_TURN = 3'd4;
	localparam logic [2:0] ST_INTERP = 3'd5;
	localparam logic [2:0] ST_AMP = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0] state_q;

	// Configuration registers.
	logic [15:0] rest_q, factor_q, dc_q;

	// Cluster tables and tick state.
	logic [15:0] amp_tab_q [CLUSTER_COUNT];
	logic [15:0] rate_tab_q [CLUSTER_COUNT];
	logic [15:0] step_tab_q [CLUSTER_COUNT];
	logic [31:0] elapsed_q;
	logic [15:0] rphase_q;
	logic [2:0] cl_q;
	logic [4:0] muscle_q;
	logic [2:0] left_q;
	logic [15:0] lo_q;
	logic [16:0] hi_q;
	logic [14:0] base_q;
	logic neg_q;
	logic [15:0] len_q;

	// Shift-add multiplier.
	logic [55:0] acc_q, mc_q;
	logic [29:0] mp_q;
	logic [4:0] cnt_q;

	// Output register.
	logic ovalid_q, olast_q;
	logic [4:0] omuscle_q;
	logic [15:0] olen_q;
	logic emit_take;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.muscle_index = omuscle_q;
	assign out_ch.target_length = olen_q;
	assign out_ch.last = olast_q;

	// A length moves into the output register when that register is free or being read.
	assign emit_take = (state_q == ST_EMIT) && (!ovalid_q || out_ch.ready);

	// Sine preparation from the finished turn product.
	logic [15:0] angle;
	logic [14:0] qoff;
	logic [14:0] tab_lo, tab_hi;
	assign angle = acc_q[55:40] + rphase_q;
	assign qoff = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign tab_lo = quarter_sine(qoff[14:10]);
	assign tab_hi = quarter_sine(qoff[14:10] + 5'd1);

	// Amplitude scaling, offset and clamping of the finished amplitude product.
	logic [30:0] mag;
	logic [31:0] mag_rnd;
	logic signed [17:0] wave, len_s;
	logic [16:0] clamped;
	assign mag = acc_q[30:0];
	assign mag_rnd = {1'b0, mag} + 32'd32767;
	// Negative products round away from zero, positive ones toward zero.
	assign wave = neg_q ? -$signed({1'b0, mag_rnd[31:15]})
		: $signed({2'b00, mag[30:15]});
	assign len_s = wave + $signed({2'b00, dc_q});
	always_comb begin
		if (len_s <= $signed({2'b00, lo_q})) begin
			clamped = {1'b0, lo_q};
		end else if (len_s >= $signed({1'b0, hi_q})) begin
			clamped = hi_q;
		end else begin
			clamped = len_s[16:0];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= 16'd4096;
			factor_q <= 16'd32768;
			dc_q <= 16'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REST_LENGTH: rest_q <= cfg_data;
				REG_STRETCH_FACTOR: factor_q <= cfg_data;
				REG_DC_OFFSET: dc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, multiplier and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elapsed_q <= '0;
			rphase_q <= '0;
			cl_q <= '0;
			muscle_q <= '0;
			left_q <= '0;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < CLUSTER_COUNT; i++) begin
				amp_tab_q[i] <= '0;
				rate_tab_q[i] <= '0;
				step_tab_q[i] <= '0;
			end
		end else begin
			// One multiplier bit per cycle.
			if (cnt_q != 5'd0) begin
				if (mp_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mc_q <= {mc_q[54:0], 1'b0};
				mp_q <= {1'b0, mp_q[29:1]};
				cnt_q <= cnt_q - 5'd1;
			end
			// Output valid rises with a new length and falls when the item is taken.
			if (emit_take) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.action == ACTION_WRITE) begin
							amp_tab_q[in_ch.cluster_index] <= in_ch.amplitude;
							rate_tab_q[in_ch.cluster_index] <= in_ch.angular_rate;
							step_tab_q[in_ch.cluster_index] <= in_ch.phase_step;
						end else begin
							elapsed_q <= elapsed_q + {16'd0, in_ch.time_step};
							acc_q <= '0;
							mc_q <= {40'd0, rest_q};
							mp_q <= {13'd0, 17'h10000 - {1'b0, factor_q}};
							cnt_q <= 5'd17;
							state_q <= ST_LIM_LO;
						end
					end
				end
				ST_LIM_LO: begin
					if (cnt_q == 5'd0) begin
						lo_q <= acc_q[31:16];
						acc_q <= '0;
						mc_q <= {40'd0, rest_q};
						mp_q <= {13'd0, 17'h10000 + {1'b0, factor_q}};
						cnt_q <= 5'd17;
						state_q <= ST_LIM_HI;
					end
				end
				ST_LIM_HI: begin
					if (cnt_q == 5'd0) begin
						hi_q <= acc_q[32:16];
						cl_q <= '0;
						muscle_q <= '0;
						rphase_q <= '0;
						acc_q <= '0;
						mc_q <= {24'd0, elapsed_q};
						mp_q <= {14'd0, rate_tab_q[0]};
						cnt_q <= 5'd16;
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					if (cnt_q == 5'd0) begin
						acc_q <= '0;
						mc_q <= {8'd0, acc_q[47:0]};
						mp_q <= TURN_SCALE;
						cnt_q <= 5'd30;
						state_q <= ST_TURN;
					end
				end
				ST_TURN: begin
					if (cnt_q == 5'd0) begin
						base_q <= tab_lo;
						neg_q <= angle[15];
						acc_q <= '0;
						mc_q <= {41'd0, tab_hi - tab_lo};
						mp_q <= {20'd0, qoff[9:0]};
						cnt_q <= 5'd10;
						state_q <= ST_INTERP;
					end
				end
				ST_INTERP: begin
					if (cnt_q == 5'd0) begin
						acc_q <= '0;
						mc_q <= {40'd0, amp_tab_q[cl_q]};
						mp_q <= {15'd0, base_q + acc_q[24:10]};
						cnt_q <= 5'd15;
						state_q <= ST_AMP;
					end
				end
				ST_AMP: begin
					if (cnt_q == 5'd0) begin
						len_q <= clamped[16] ? 16'hFFFF : clamped[15:0];
						left_q <= (cl_q < FIRST_PAIR_CLUSTER) ? 3'd4 : 3'd2;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// Hand one length to the output register when it is free or being read.
					if (emit_take) begin
						omuscle_q <= muscle_q;
						olen_q <= len_q;
						olast_q <= (muscle_q == LAST_MUSCLE);
						muscle_q <= muscle_q + 5'd1;
						left_q <= left_q - 3'd1;
						if (left_q == 3'd1) begin
							rphase_q <= rphase_q + step_tab_q[cl_q];
							if (cl_q == LAST_CLUSTER) begin
								state_q <= ST_IDLE;
							end else begin
								cl_q <= cl_q + 3'd1;
								acc_q <= '0;
								mc_q <= {24'd0, elapsed_q};
								mp_q <= {14'd0, rate_tab_q[cl_q + 3'd1]};
								cnt_q <= 5'd16;
								state_q <= ST_RATE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The flagged item is always muscle 23.
	a_last_muscle: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && olast_q |-> omuscle_q == LAST_MUSCLE)
		else $error("last flag on a muscle other than the final one");

	// Emission never runs with an empty cluster count.
	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> left_q != 3'd0)
		else $error("emitting with no muscles left in the cluster");

	// The multiplier is quiet whenever the block waits for items.
	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q == 5'd0)
		else $error("multiplier busy while idle");

	// A tick leaves the idle state and restarts from the limits.
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.action == ACTION_TICK |=> state_q == ST_LIM_LO)
		else $error("tick item did not start the sequence");

endmodule

>>> verif/csl_tb_if.sv
// Testbench-side copy of nothing: the channels come from the RTL interfaces.
// This file holds the length predictor package used by the checker; depends on csl_pkg.
`timescale 1ns / 100ps
package csl_tb_pkg;
	import csl_pkg::*;

	typedef struct packed {
		logic [4:0] muscle_index;
		logic [15:0] target_length;
		logic last;
	} length_item_t;

	// Sine of a binary angle, Q1.15, from the quarter table with floored interpolation.
	function automatic int sine_of_angle(logic [15:0] a);
		int r, idx, frac, v, s0, s1;
		r = a[13:0];
		if (a[14]) r = 16384 - r;
		idx = r >> 10;
		frac = r & 1023;
		if (idx >= 16) v = 32767;
		else begin
			s0 = quarter_sine(idx[4:0]);
			s1 = quarter_sine(5'(idx + 1));
			v = s0 + (((s1 - s0) * frac) >>> 10);
		end
		return a[15] ? -v : v;
	endfunction

	// Angle reached by one cluster: rate times time scaled to 65536 per turn.
	function automatic logic [15:0] angle_of(logic [15:0] rate, logic [31:0] t);
		logic [63:0] p, hi, lo, sum;
		p = 64'(rate) * 64'(t);
		hi = (p >> 24) * 64'd683565276;
		lo = (p & 64'hFFFFFF) * 64'd683565276;
		sum = hi + (lo >> 24);
		return sum[31:16];
	endfunction
endpackage

>>> verif/csl_length_checker.sv
// Checker: watches both channels and the register port, predicts the lengths and compares.
// Depends on csl_pkg, csl_tb_pkg and the RTL channel interfaces.
`timescale 1ns / 100ps
module csl_length_checker (
	input logic clk,
	input logic arst_n,
	csl_in_if in_ch,
	csl_out_if out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output int fail_count,
	output int pending_lengths
);
	import csl_pkg::*;
	import csl_tb_pkg::*;

	logic [15:0] rest_len, stretch, dc;
	logic [31:0] elapsed;
	logic [15:0] amp_tab[8], rate_tab[8], step_tab[8];
	length_item_t lengths_due[$];

	assign pending_lengths = lengths_due.size();

	function automatic int cluster_of_muscle(int m);
		return (m < 16) ? (m >> 2) : 4 + ((m - 16) >> 1);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: %s got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Expected lengths of one tick at the current settings.
	task automatic predict_tick(logic [15:0] dt);
		longint lo, hi, prod, wave, len;
		logic [15:0] phase, ang;
		length_item_t it;
		int c;
		elapsed = elapsed + 32'(dt);
		phase = 0;
		lo = (longint'(rest_len) * (65536 - longint'(stretch))) >>> 16;
		hi = (longint'(rest_len) * (65536 + longint'(stretch))) >>> 16;
		for (int m = 0; m < 24; m++) begin
			c = cluster_of_muscle(m);
			ang = angle_of(rate_tab[c], elapsed) + phase;
			prod = longint'(amp_tab[c]) * longint'(sine_of_angle(ang));
			if (prod >= 0) wave = prod >>> 15;
			else wave = -((-prod + 32767) >>> 15);
			len = wave + longint'(dc);
			if (len <= lo) len = lo;
			else if (len >= hi) len = hi;
			if (len > 65535) len = 65535;
			if (len < 0) len = 0;
			it.muscle_index = 5'(m);
			it.target_length = 16'(len);
			it.last = (m == 23);
			lengths_due = {lengths_due, it};
			if (m == 23 || cluster_of_muscle(m + 1) != c) phase = phase + step_tab[c];
		end
	endtask

	// Model update and comparison at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		length_item_t want;
		if (!arst_n) begin
			rest_len <= 16'd4096;
			stretch <= 16'd32768;
			dc <= 16'd4096;
			elapsed = 0;
			for (int i = 0; i < 8; i++) begin
				amp_tab[i] = 0;
				rate_tab[i] = 0;
				step_tab[i] = 0;
			end
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REST_LENGTH: rest_len <= cfg_data;
					REG_STRETCH_FACTOR: stretch <= cfg_data;
					REG_DC_OFFSET: dc <= cfg_data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (lengths_due.size() == 0) begin
					report_mismatch("unexpected length, muscle", out_ch.muscle_index, -1);
				end else begin
					want = lengths_due.pop_front();
					if (out_ch.muscle_index !== want.muscle_index)
						report_mismatch("muscle_index", out_ch.muscle_index, want.muscle_index);
					if (out_ch.target_length !== want.target_length)
						report_mismatch("target_length", out_ch.target_length,
							want.target_length);
					if (out_ch.last !== want.last)
						report_mismatch("last", out_ch.last, want.last);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.action == ACTION_WRITE) begin
					amp_tab[in_ch.cluster_index] = in_ch.amplitude;
					rate_tab[in_ch.cluster_index] = in_ch.angular_rate;
					step_tab[in_ch.cluster_index] = in_ch.phase_step;
				end else begin
					predict_tick(in_ch.time_step);
				end
			end
		end
	end
endmodule

>>> verif/tb_clustered_sine_length_generator.sv
// Testbench top: drives writes, ticks and register settings, and gives the verdict.
// Depends on csl_pkg, the RTL interfaces, csl_length_checker and the block itself.
`timescale 1ns / 100ps
module tb_clustered_sine_length_generator;
	import csl_pkg::*;

	// An index past the register list; writes to it have no effect.
	localparam logic [1:0] REG_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	int fail_count, pending_lengths;
	bit quiet;        // no idling on either side
	int hold_off;     // long receiver stall, in cycles

	csl_in_if in_ch();
	csl_out_if out_ch();

	clustered_sine_length_generator i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	csl_length_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_lengths(pending_lengths)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Run limit well above the slowest correct run.
	initial begin
		#400ms;
		$display("Mismatches found");
		$finish;
	end

	// Receiver: random stall bursts, and a long hold-off on request.
	initial begin
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ch.ready <= 0;
				hold_off--;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	// Offer one item and wait for it to be taken; a random gap may come first.
	task automatic send_item(logic act, logic [2:0] c, logic [15:0] a, logic [15:0] r,
		logic [15:0] p, logic [15:0] dt);
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) @(negedge clk);
		in_ch.valid = 1;
		in_ch.action = act;
		in_ch.cluster_index = c;
		in_ch.amplitude = a;
		in_ch.angular_rate = r;
		in_ch.phase_step = p;
		in_ch.time_step = dt;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 0;
	endtask

	task automatic write_cluster(logic [2:0] c, logic [15:0] a, logic [15:0] r,
		logic [15:0] p);
		send_item(ACTION_WRITE, c, a, r, p, 16'($urandom));
	endtask

	task automatic tick(logic [15:0] dt);
		send_item(ACTION_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), dt);
	endtask

	// Wait for every expected length, then let the block settle before a register write.
	task automatic drain();
		while (pending_lengths != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [15:0] v);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_writes(int n);
		for (int i = 0; i < n; i++)
			write_cluster(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n = 0;
		quiet = 0;
		hold_off = 0;
		cfg_we = 0;
		cfg_index = REG_REST_LENGTH;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.action = ACTION_WRITE;
		in_ch.cluster_index = 0;
		in_ch.amplitude = 0;
		in_ch.angular_rate = 0;
		in_ch.phase_step = 0;
		in_ch.time_step = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: ticks at reset tables, zero time step, extreme fields.
		tick(16'd0);
		tick(16'hFFFF);
		write_cluster(3'd0, 16'hFFFF, 16'hFFFF, 16'h7FFF);
		write_cluster(3'd1, 16'h1000, 16'h0100, 16'h8000);
		write_cluster(3'd2, 16'h0800, 16'h0000, 16'h4000);
		write_cluster(3'd3, 16'h0000, 16'h3243, 16'hC000);
		write_cluster(3'd4, 16'h2000, 16'h0080, 16'h0000);
		write_cluster(3'd5, 16'hFFFF, 16'h0001, 16'hFFFF);
		write_cluster(3'd6, 16'h7FFF, 16'h8000, 16'h2000);
		write_cluster(3'd7, 16'h0001, 16'h00FF, 16'h8001);
		tick(16'd1);
		tick(16'hFFFF);
		tick(16'h8000);
		drain();
		// Wide limits, then a zero window at full scale, then a zero rest length.
		set_reg(REG_STRETCH_FACTOR, 16'hFFFF);
		set_reg(REG_REST_LENGTH, 16'hFFFF);
		set_reg(REG_DC_OFFSET, 16'h8000);
		tick(16'h1234);
		tick(16'h4321);
		drain();
		set_reg(REG_STRETCH_FACTOR, 16'h0000);
		set_reg(REG_DC_OFFSET, 16'hFFFF);
		tick(16'h0100);
		drain();
		set_reg(REG_REST_LENGTH, 16'h0000);
		set_reg(REG_DC_OFFSET, 16'h0000);
		tick(16'h0200);
		drain();

		// Pressure: long receiver stall while items are offered.
		set_reg(REG_REST_LENGTH, 16'd4096);
		set_reg(REG_STRETCH_FACTOR, 16'hC000);
		set_reg(REG_DC_OFFSET, 16'd4096);
		hold_off = 2000;
		tick(16'h0777);
		tick(16'h0888);
		write_cluster(3'd2, 16'h1FFF, 16'h1200, 16'h1111);
		tick(16'h0999);
		drain();

		// Random phases with fresh register settings.
		for (int ph = 0; ph < 8; ph++) begin
			set_reg(REG_REST_LENGTH, 16'($urandom_range(0, 65535)));
			set_reg(REG_STRETCH_FACTOR, 16'($urandom));
			set_reg(REG_DC_OFFSET, 16'($urandom_range(2048, 12288)));
			if (ph == 7) quiet = 1;
			for (int k = 0; k < 29; k++) begin
				if ($urandom_range(0, 2) == 0) random_writes($urandom_range(1, 3));
				tick(16'($urandom_range(0, 65535)));
			end
			drain();
		end
		// A write to a register index beyond the list is ignored.
		set_reg(REG_NONE, 16'hFFFF);
		tick(16'd77);
		drain();

		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
